FILE: hw/rtl/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types, constants and tables of the matrix transform accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_IDENTITY  = 4'd0,
        OP_LOAD      = 4'd1,
        OP_MULTIPLY  = 4'd2,
        OP_SCALE     = 4'd3,
        OP_TRANSLATE = 4'd4,
        OP_ROTX      = 4'd5,
        OP_ROTY      = 4'd6,
        OP_ROTZ      = 4'd7,
        OP_READ      = 4'd8
    } op_t;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int CORDIC_ITER_DEF = 16;
    localparam int ANG_FRAC        = 24;
    localparam int VEC_FRAC        = 30;
    localparam int ATAN_DEPTH      = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // arctangent table in degrees, 24 fraction bits
    function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd754974720;
            5'd1:  v = 32'sd445687602;
            5'd2:  v = 32'sd235489088;
            5'd3:  v = 32'sd119537938;
            5'd4:  v = 32'sd60000934;
            5'd5:  v = 32'sd30029717;
            5'd6:  v = 32'sd15018523;
            5'd7:  v = 32'sd7509720;
            5'd8:  v = 32'sd3754917;
            5'd9:  v = 32'sd1877466;
            5'd10: v = 32'sd938734;
            5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;
            5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;
            5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;
            5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;
            5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;
            5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;
            5'd23: v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/mta_cordic.sv
// ----------------------------------------------------------------------------
// mta_cordic
// Iterative sine/cosine of an angle in degrees: range reduction, one
// CORDIC step per cycle, rounding to the output fraction.
// ----------------------------------------------------------------------------
module mta_cordic #(
    parameter int FRAC_BITS   = mta_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITER = mta_pkg::CORDIC_ITER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] sin_out,
    output logic signed [31:0] cos_out
);

    localparam int ITERS = (CORDIC_ITER < mta_pkg::ATAN_DEPTH) ? CORDIC_ITER
                                                               : mta_pkg::ATAN_DEPTH;
    localparam int RSH   = mta_pkg::VEC_FRAC - FRAC_BITS;
    localparam int ZSH   = mta_pkg::ANG_FRAC - FRAC_BITS;
    // number of halving steps so that 360 << MOD_STEPS covers 2^31
    localparam int MOD_STEPS = (FRAC_BITS < 23) ? 23 - FRAC_BITS : 0;
    localparam logic signed [40:0] FULL     = 41'sd360 <<< FRAC_BITS;
    localparam logic signed [40:0] HALF     = 41'sd180 <<< FRAC_BITS;
    localparam logic signed [40:0] QUARTER  = 41'sd90 <<< FRAC_BITS;
    localparam logic signed [40:0] FULL_TOP = FULL <<< MOD_STEPS;

    typedef enum logic [2:0] {S_IDLE, S_MOD, S_FOLD, S_ITER, S_DONE} state_t;

    state_t             state_reg;
    logic signed [40:0] r_reg;
    logic [3:0]         m_reg;
    logic               flip_reg;
    logic signed [34:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         i_reg;
    logic signed [31:0] sin_reg, cos_reg;

    logic signed [34:0] dx, dy;
    logic signed [34:0] xr, yr;
    logic signed [31:0] cr, sr;
    logic signed [40:0] r_fold;
    logic               fold_flip;
    logic signed [40:0] r_sub;
    logic signed [40:0] mod_step;

    // one rotation step, and rounding of x and y to the output fraction
    always_comb
    begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        xr = x_reg + (35'sd1 <<< (RSH - 1));
        yr = y_reg + (35'sd1 <<< (RSH - 1));
        cr = 32'(xr >>> RSH);
        sr = 32'(yr >>> RSH);
    end

    // shifted multiple of 360 degrees for the current reduction step
    always_comb
    begin
        mod_step = FULL <<< m_reg;
    end

    // fold into [-90, 90]
    always_comb
    begin
        r_sub     = (r_reg >= HALF) ? r_reg - FULL : r_reg;
        r_fold    = r_sub;
        fold_flip = 1'b0;
        if (r_sub > QUARTER)
        begin
            r_fold    = HALF - r_sub;
            fold_flip = 1'b1;
        end
        else if (r_sub < -QUARTER)
        begin
            r_fold    = -HALF - r_sub;
            fold_flip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg     <= '0;
            m_reg     <= '0;
            flip_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            i_reg     <= '0;
            sin_reg   <= '0;
            cos_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                // negative angles move up by a multiple of 360 degrees
                S_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= (angle < 0) ? 41'(angle) + FULL_TOP : 41'(angle);
                        m_reg     <= 4'(MOD_STEPS);
                        state_reg <= S_MOD;
                    end
                end
                // bring the angle into [0, 360) by compare/subtract of
                // 360 << m, m counting down to zero
                S_MOD:
                begin
                    if (r_reg >= mod_step)
                        r_reg <= r_reg - mod_step;
                    if (m_reg == 4'd0)
                        state_reg <= S_FOLD;
                    else
                        m_reg <= m_reg - 4'd1;
                end
                S_FOLD:
                begin
                    flip_reg  <= fold_flip;
                    z_reg     <= 34'(r_fold <<< ZSH);
                    x_reg     <= 35'(mta_pkg::CORDIC_GAIN);
                    y_reg     <= '0;
                    i_reg     <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - 34'(mta_pkg::atan_deg(i_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + 34'(mta_pkg::atan_deg(i_reg));
                    end
                    if (i_reg == 5'(ITERS - 1))
                        state_reg <= S_DONE;
                    i_reg <= i_reg + 5'd1;
                end
                S_DONE:
                begin
                    sin_reg   <= sr;
                    cos_reg   <= flip_reg ? -cr : cr;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done    = (state_reg == S_DONE);
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

FILE: hw/rtl/matrix_transform_accumulator.sv
// ----------------------------------------------------------------------------
// matrix_transform_accumulator
// 4x4 Q16.16 transform builder with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_axis channel; tdata carries value_x,
// value_y, value_z and angle_degrees, tuser carries operation and
// element_index. Transform commands compose onto the right of the current
// matrix: current = current * T. A read command (operation 8) sends sixteen
// transfers on m_axis, index 0..15 row-major, tlast on the sixteenth, tuser
// carrying the saturation flag seen since the previous read.
// Sequencing: s_axis_tready is high only while the sequencer is idle.
// Identity, load and undefined codes are done when taken. A multiply-type
// command builds T, then works through 16 elements, each with four
// registered products, the last accumulate and round/saturate, then copies
// back. Rotations first compute sine/cosine (at the default parameters:
// start, 8 compare/subtract steps of range reduction, fold, 16 CORDIC
// steps, rounding), in the same time whatever the angle.
// A read sends one transfer per cycle while m_axis_tready stays high; a
// stalled receiver holds the current transfer and the block waits.
// Reset sets the current and operand matrices to identity and clears the saturation flag.
// ----------------------------------------------------------------------------
module matrix_transform_accumulator #(
    parameter int FRAC_BITS   = mta_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITER = mta_pkg::CORDIC_ITER_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // value_x [31:0], value_y [63:32], value_z [95:64], angle_degrees [127:96]
    input  logic [127:0] s_axis_tdata,
    // operation [3:0], element_index [7:4]
    input  logic [7:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_index [3:0], out_value [35:4], zero fill [39:36]
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // saturated
    output logic         m_axis_tuser
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_TRIG, S_BUILD, S_MAC, S_ROUND, S_COPY, S_READ
    } state_t;

    state_t             state_reg;
    logic [31:0]        cur_reg [16];
    logic [31:0]        opd_reg [16];
    logic signed [31:0] t_reg   [16];
    logic [31:0]        nxt_reg [16];
    logic               sat_reg;
    logic               sat_snap_reg;
    logic [3:0]         op_reg;
    logic [31:0]        vx_reg, vy_reg, vz_reg;
    logic [31:0]        ang_reg;
    logic [3:0]         elem_reg;   // r*4+c
    logic [1:0]         k_reg;
    logic               prod_valid_reg;
    logic               prod_last_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic [3:0]         rd_reg;
    logic               cordic_start_reg;

    logic               cordic_done;
    logic signed [31:0] sin_v, cos_v;
    logic               cordic_go;
    logic signed [31:0] t_next  [16];

    logic signed [31:0] mul_a, mul_b;
    logic signed [65:0] acc_sum;
    logic signed [65:0] rounded;
    logic signed [65:0] shifted;
    logic [31:0]        sat_val;
    logic               sat_hit;

    mta_cordic #(
        .FRAC_BITS   (FRAC_BITS),
        .CORDIC_ITER (CORDIC_ITER)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start_reg),
        .angle   (ang_reg),
        .done    (cordic_done),
        .sin_out (sin_v),
        .cos_out (cos_v)
    );

    // rotation command taken this cycle
    always_comb
    begin
        cordic_go = 1'b0;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            case (s_axis_tuser[3:0])
                mta_pkg::OP_ROTX, mta_pkg::OP_ROTY, mta_pkg::OP_ROTZ: cordic_go = 1'b1;
                default: cordic_go = 1'b0;
            endcase
        end
    end

    // right-hand matrix for the held command
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            t_next[i] = (i % 5 == 0) ? ONE : '0;
        case (op_reg)
            mta_pkg::OP_MULTIPLY:
                for (int i = 0; i < 16; i++)
                    t_next[i] = opd_reg[i];
            mta_pkg::OP_SCALE:
            begin
                t_next[0]  = vx_reg;
                t_next[5]  = vy_reg;
                t_next[10] = vz_reg;
            end
            mta_pkg::OP_TRANSLATE:
            begin
                t_next[12] = vx_reg;
                t_next[13] = vy_reg;
                t_next[14] = vz_reg;
            end
            mta_pkg::OP_ROTX:
            begin
                t_next[5] = cos_v; t_next[6] = sin_v;
                t_next[9] = -sin_v; t_next[10] = cos_v;
            end
            mta_pkg::OP_ROTY:
            begin
                t_next[0] = cos_v; t_next[2] = -sin_v;
                t_next[8] = sin_v; t_next[10] = cos_v;
            end
            mta_pkg::OP_ROTZ:
            begin
                t_next[0] = cos_v; t_next[1] = sin_v;
                t_next[4] = -sin_v; t_next[5] = cos_v;
            end
            default: ;
        endcase
    end

    // shared multiplier operands: current[r][k] * T[k][c]
    always_comb
    begin
        mul_a = cur_reg[{elem_reg[3:2], k_reg}];
        mul_b = t_reg[{k_reg, elem_reg[1:0]}];
    end

    // accumulate, round and saturate
    always_comb
    begin
        acc_sum = acc_reg + 66'(prod_reg);
        rounded = acc_reg + (66'sd1 <<< (FRAC_BITS - 1));
        shifted = rounded >>> FRAC_BITS;
        sat_hit = 1'b0;
        sat_val = shifted[31:0];
        if (shifted > 66'sh7FFFFFFF)
        begin
            sat_val = 32'h7FFFFFFF;
            sat_hit = 1'b1;
        end
        else if (shifted < -66'sh80000000)
        begin
            sat_val = 32'h80000000;
            sat_hit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sat_reg          <= 1'b0;
            sat_snap_reg     <= 1'b0;
            op_reg           <= '0;
            ang_reg          <= '0;
            elem_reg         <= '0;
            k_reg            <= '0;
            prod_valid_reg   <= 1'b0;
            prod_last_reg    <= 1'b0;
            rd_reg           <= '0;
            cordic_start_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                cur_reg[i] <= (i % 5 == 0) ? ONE : '0;
                opd_reg[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end
        else
        begin
            cordic_start_reg <= cordic_go;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg  <= s_axis_tuser[3:0];
                        vx_reg  <= s_axis_tdata[31:0];
                        vy_reg  <= s_axis_tdata[63:32];
                        vz_reg  <= s_axis_tdata[95:64];
                        ang_reg <= s_axis_tdata[127:96];
                        case (s_axis_tuser[3:0])
                            mta_pkg::OP_IDENTITY:
                                for (int i = 0; i < 16; i++)
                                    cur_reg[i] <= (i % 5 == 0) ? ONE : '0;
                            mta_pkg::OP_LOAD:
                                opd_reg[s_axis_tuser[7:4]] <= s_axis_tdata[31:0];
                            mta_pkg::OP_MULTIPLY, mta_pkg::OP_SCALE,
                            mta_pkg::OP_TRANSLATE:
                                state_reg <= S_BUILD;
                            mta_pkg::OP_ROTX, mta_pkg::OP_ROTY, mta_pkg::OP_ROTZ:
                                state_reg <= S_TRIG;
                            mta_pkg::OP_READ:
                            begin
                                sat_snap_reg <= sat_reg;
                                rd_reg       <= '0;
                                state_reg    <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                // wait for sine and cosine of the held angle
                S_TRIG:
                begin
                    if (cordic_done)
                        state_reg <= S_BUILD;
                end
                // build the right-hand matrix
                S_BUILD:
                begin
                    for (int i = 0; i < 16; i++)
                        t_reg[i] <= t_next[i];
                    elem_reg       <= '0;
                    k_reg          <= '0;
                    acc_reg        <= '0;
                    prod_valid_reg <= 1'b0;
                    prod_last_reg  <= 1'b0;
                    state_reg      <= S_MAC;
                end
                // one product per cycle, registered, then accumulated
                S_MAC:
                begin
                    if (!prod_last_reg)
                    begin
                        prod_reg       <= mul_a * mul_b;
                        prod_valid_reg <= 1'b1;
                        prod_last_reg  <= (k_reg == 2'd3);
                        k_reg          <= k_reg + 2'd1;
                    end
                    else
                        prod_valid_reg <= 1'b0;
                    if (prod_valid_reg)
                        acc_reg <= acc_sum;
                    if (prod_last_reg && prod_valid_reg)
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    nxt_reg[elem_reg] <= sat_val;
                    if (sat_hit)
                        sat_reg <= 1'b1;
                    acc_reg        <= '0;
                    prod_valid_reg <= 1'b0;
                    prod_last_reg  <= 1'b0;
                    elem_reg       <= elem_reg + 4'd1;
                    state_reg      <= (elem_reg == 4'd15) ? S_COPY : S_MAC;
                end
                S_COPY:
                begin
                    for (int i = 0; i < 16; i++)
                        cur_reg[i] <= nxt_reg[i];
                    state_reg <= S_IDLE;
                end
                S_READ:
                begin
                    if (m_axis_tready)
                    begin
                        rd_reg <= rd_reg + 4'd1;
                        if (rd_reg == 4'd15)
                        begin
                            sat_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a command is taken in idle only; its fields are held in registers
    assign s_axis_tready = (state_reg == S_IDLE);

    assign m_axis_tvalid = (state_reg == S_READ);
    assign m_axis_tdata  = {4'd0, cur_reg[rd_reg], rd_reg};
    assign m_axis_tlast  = (rd_reg == 4'd15);
    assign m_axis_tuser  = sat_snap_reg;

endmodule
